>>> rtl/core/greedy_nearest_pair_matcher_core_macros.svh
// Assertion helpers for the matcher core.
`ifndef GREEDY_NEAREST_PAIR_MATCHER_CORE_MACROS_SVH
`define GREEDY_NEAREST_PAIR_MATCHER_CORE_MACROS_SVH

// Clocked check, muted while reset is high.
`define GNPM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define GNPM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/gnpm_pkg.sv
package gnpm_pkg;

  localparam int IN_COORD_W = 24;
  localparam int BOX_W      = 24;
  localparam int MAG_W      = 25;
  localparam int SQ_W       = 50;
  localparam int ROOT_W     = 25;
  localparam int DIST_W     = 24;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // (0.001 nm * 65536)^2 rounded up, in Q18.32 nm^2
  localparam logic [SQ_W-1:0]  MIN_SQ    = SQ_W'(4295);
  localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(25'h1000000);

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CUT,
    ST_PRD,
    ST_AXIS,
    ST_PWR,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT,
    ST_TAKE,
    ST_SQRT
  } state_t;

  // sqrt unit handshake
  typedef struct packed {
    logic start;
    logic done;
  } sqrt_ctl_t;

endpackage

>>> rtl/core/gnpm_sq_unit.sv
// Shared axis unit: difference, one periodic fold, magnitude, square; in mag mode it squares the mag input instead.
// The magnitude and then its square are registered; takes a new operand every cycle.
module gnpm_sq_unit #(
  parameter int CW = 24
) (
  input  logic                         clk,
  input  logic                         mag_mode,
  input  logic [gnpm_pkg::MAG_W-1:0]   mag,
  input  logic signed [CW-1:0]         pa,
  input  logic signed [CW-1:0]         pb,
  input  logic [gnpm_pkg::BOX_W-1:0]   len,
  output logic [gnpm_pkg::SQ_W-1:0]    sq,
  output logic                         big
);

  localparam int DW = (CW + 3 > 27) ? CW + 3 : 27;

  logic signed [DW-1:0] d, d2, len_s, fd;
  logic [DW-1:0]        m_full;
  logic                 big_c;
  logic [gnpm_pkg::MAG_W-1:0] m_c;
  logic [gnpm_pkg::MAG_W-1:0] m_q;
  logic                 big_q;

  always_comb begin
    d      = DW'(pa) - DW'(pb);
    d2     = d <<< 1;
    len_s  = DW'($signed({1'b0, len}));
    if (d2 > len_s) begin
      fd = d - len_s;
    end else if (d2 < -len_s) begin
      fd = d + len_s;
    end else begin
      fd = d;
    end
    m_full = (fd < 0) ? DW'(-fd) : DW'(fd);
    if (mag_mode) begin
      big_c = 1'b0;
      m_c   = mag;
    end else begin
      big_c = m_full > DW'(gnpm_pkg::MAG_LIMIT);
      m_c   = m_full[gnpm_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    m_q   <= m_c;
    big_q <= big_c;
    sq    <= gnpm_pkg::SQ_W'(m_q * m_q);
    big   <= big_q;
  end

endmodule

>>> rtl/core/gnpm_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module gnpm_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gnpm_pkg::SQ_W-1:0]     radicand,
  output gnpm_pkg::sqrt_ctl_t           ctl,
  output logic [gnpm_pkg::ROOT_W-1:0]   root
);

  localparam int RW = gnpm_pkg::ROOT_W + 3;

  logic                          busy;
  logic [4:0]                    cnt;
  logic [gnpm_pkg::SQ_W-1:0]     rad;
  logic [RW-1:0]                 rem;
  logic [RW-1:0]                 rem_sh, trial;

  always_comb begin
    rem_sh = {rem[RW-3:0], rad[gnpm_pkg::SQ_W-1 -: 2]};
    trial  = RW'({root, 2'b01});
  end

  assign ctl.start = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      ctl.done <= 1'b0;
    end else begin
      ctl.done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(gnpm_pkg::ROOT_W - 1);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= rad << 2;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[gnpm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[gnpm_pkg::ROOT_W-2:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          busy     <= 1'b0;
          ctl.done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule

>>> rtl/core/greedy_nearest_pair_matcher_core.sv
// Greedy nearest-pair matcher. Load words (tuser 0 = group A, 1 = group B)
// write one particle position each. A run word (tuser 2) squares the
// cutoff, then computes every in-use A-B pair through one shared
// fold-and-square unit, storing each squared distance with a keep flag in
// the pair memory. It then picks pairs greedily: each pick is a full scan
// of the pair memory at one pair per cycle, the drain and decide steps that
// settle the compare, an emit step that hands the previous pick to the
// output register and waits out any output stall, a retire step and a
// bit-serial square root. The counts are capped at MAX_A and MAX_B, and a
// zero count goes straight to the empty word. The pair memory read port
// sets the scan rate. Results are words on the master side, one per match,
// the final one with tlast; a run with no match gives one word with tuser 0.
// The slave side is ready only while no run is in progress.
module greedy_nearest_pair_matcher_core #(
  parameter int MAX_A      = 64,
  parameter int MAX_B      = 64,
  parameter int COORD_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // particle_index[5:0], coord_x, coord_y, coord_z, pad
  input  logic [1:0]  s_tuser,   // action[1:0]
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // a_index[5:0], b_index[5:0], pair_distance[23:0], pad
  output logic        m_tuser,   // pair_valid
  output logic        m_tlast,   // last
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gnpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gnpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW  = COORD_BITS;
  localparam int AW  = (MAX_A > 1) ? $clog2(MAX_A) : 1;
  localparam int BW  = (MAX_B > 1) ? $clog2(MAX_B) : 1;
  localparam int NAW = $clog2(MAX_A + 1);
  localparam int NBW = $clog2(MAX_B + 1);
  localparam int PW  = gnpm_pkg::SQ_W + 1;

  // config registers
  logic [gnpm_pkg::CNT_W-1:0] count_a, count_b;
  logic [gnpm_pkg::BOX_W-1:0] cutoff, box_x, box_y, box_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= 7'd64;
      count_b <= 7'd64;
      cutoff  <= 24'd32768;
      box_x   <= 24'd655360;
      box_y   <= 24'd655360;
      box_z   <= 24'd655360;
    end else if (cfg_valid) begin
      case (cfg_index)
        gnpm_pkg::REG_COUNT_A: count_a <= cfg_data[gnpm_pkg::CNT_W-1:0];
        gnpm_pkg::REG_COUNT_B: count_b <= cfg_data[gnpm_pkg::CNT_W-1:0];
        gnpm_pkg::REG_CUTOFF:  cutoff  <= cfg_data;
        gnpm_pkg::REG_BOX_X:   box_x   <= cfg_data;
        gnpm_pkg::REG_BOX_Y:   box_y   <= cfg_data;
        gnpm_pkg::REG_BOX_Z:   box_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  // counts saturated to the array size
  logic [9:0]     ca10, cb10;
  logic [NAW-1:0] na;
  logic [NBW-1:0] nb;
  always_comb begin
    ca10 = 10'(count_a);
    cb10 = 10'(count_b);
    na   = (ca10 > 10'(MAX_A)) ? NAW'(MAX_A) : NAW'(ca10);
    nb   = (cb10 > 10'(MAX_B)) ? NBW'(MAX_B) : NBW'(cb10);
  end

  // input word fields
  logic [5:0]    in_idx;
  logic [31:0]   zx, zy, zz;
  logic [3*CW-1:0] in_pos;
  logic          s_acc;
  always_comb begin
    in_idx = s_tdata[5:0];
    zx     = 32'(s_tdata[29:6]);
    zy     = 32'(s_tdata[53:30]);
    zz     = 32'(s_tdata[77:54]);
    in_pos = {zz[CW-1:0], zy[CW-1:0], zx[CW-1:0]};
    s_acc  = s_tvalid && s_tready;
  end

  gnpm_pkg::state_t state, state_next;

  logic [AW-1:0]  a_cnt;
  logic [BW-1:0]  b_cnt;
  logic [2:0]     k;
  logic           a_end, b_end;
  always_comb begin
    a_end = (NAW'(a_cnt) + NAW'(1)) == na;
    b_end = (NBW'(b_cnt) + NBW'(1)) == nb;
  end

  // position memories, {z, y, x}
  logic [3*CW-1:0] mem_a [MAX_A];
  logic [3*CW-1:0] mem_b [MAX_B];
  logic [3*CW-1:0] rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == gnpm_pkg::ACT_LOAD_A && 9'(in_idx) < 9'(MAX_A)) begin
      mem_a[AW'(in_idx)] <= in_pos;
    end
    if (s_acc && s_tuser == gnpm_pkg::ACT_LOAD_B && 9'(in_idx) < 9'(MAX_B)) begin
      mem_b[BW'(in_idx)] <= in_pos;
    end
    rd_a <= mem_a[a_cnt];
    rd_b <= mem_b[b_cnt];
  end

  // shared fold-and-square unit
  logic signed [CW-1:0]         op_a, op_b;
  logic [gnpm_pkg::BOX_W-1:0]   op_len;
  logic [gnpm_pkg::SQ_W-1:0]    sq;
  logic                         big;

  always_comb begin
    case (k)
      3'd1: begin
        op_a = rd_a[2*CW-1:CW]; op_b = rd_b[2*CW-1:CW]; op_len = box_y;
      end
      3'd2: begin
        op_a = rd_a[3*CW-1:2*CW]; op_b = rd_b[3*CW-1:2*CW]; op_len = box_z;
      end
      default: begin
        op_a = rd_a[CW-1:0]; op_b = rd_b[CW-1:0]; op_len = box_x;
      end
    endcase
  end

  gnpm_sq_unit #(.CW(CW)) u_sq (
    .clk      (clk),
    .mag_mode (state == gnpm_pkg::ST_CUT),
    .mag      (gnpm_pkg::MAG_W'(cutoff)),
    .pa       (op_a),
    .pb       (op_b),
    .len      (op_len),
    .sq       (sq),
    .big      (big)
  );

  // pair memory: {keep, squared distance}
  logic [PW-1:0]              pmem [2**(AW+BW)];
  logic [PW-1:0]              pm_q;
  logic [gnpm_pkg::SQ_W-1:0]  acc, cut_sq;
  logic                       rej, keep;
  logic                       pm_we;

  assign keep  = !rej && acc >= gnpm_pkg::MIN_SQ && acc <= cut_sq;
  assign pm_we = state == gnpm_pkg::ST_PWR;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[{a_cnt, b_cnt}] <= {keep, acc};
    end
    pm_q <= pmem[{a_cnt, b_cnt}];
  end

  // scan compare stage
  logic                       tag_v;
  logic [AW-1:0]              ta, best_a;
  logic [BW-1:0]              tb, best_b;
  logic [gnpm_pkg::SQ_W-1:0]  best_sq;
  logic                       found;
  logic [MAX_A-1:0]           row_used;
  logic [MAX_B-1:0]           col_used;
  logic                       better;

  always_comb begin
    better = tag_v && pm_q[PW-1] && !row_used[ta] && !col_used[tb] &&
             (!found || pm_q[gnpm_pkg::SQ_W-1:0] < best_sq);
  end

  // square root of the chosen pair
  gnpm_pkg::sqrt_ctl_t        sctl;
  logic [gnpm_pkg::ROOT_W-1:0] root;

  gnpm_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == gnpm_pkg::ST_TAKE),
    .radicand (best_sq),
    .ctl      (sctl),
    .root     (root)
  );

  // pending match, held until the next scan tells whether it is the last
  logic                       have_pend, emit_final;
  logic [AW-1:0]              pend_a;
  logic [BW-1:0]              pend_b;
  logic [gnpm_pkg::DIST_W-1:0] pend_d;
  logic                       out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == gnpm_pkg::ST_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      gnpm_pkg::ST_IDLE:
        if (s_acc && s_tuser == gnpm_pkg::ACT_RUN) state_next = gnpm_pkg::ST_CUT;
      gnpm_pkg::ST_CUT:
        if (k == 3'd2) begin
          if (na == '0 || nb == '0) state_next = gnpm_pkg::ST_DECIDE;
          else                      state_next = gnpm_pkg::ST_PRD;
        end
      gnpm_pkg::ST_PRD:  state_next = gnpm_pkg::ST_AXIS;
      gnpm_pkg::ST_AXIS: if (k == 3'd4) state_next = gnpm_pkg::ST_PWR;
      gnpm_pkg::ST_PWR:
        if (a_end && b_end) state_next = gnpm_pkg::ST_SCAN;
        else                state_next = gnpm_pkg::ST_PRD;
      gnpm_pkg::ST_SCAN:  if (a_end && b_end) state_next = gnpm_pkg::ST_DRAIN;
      gnpm_pkg::ST_DRAIN: state_next = gnpm_pkg::ST_DECIDE;
      gnpm_pkg::ST_DECIDE:
        if (found && !have_pend) state_next = gnpm_pkg::ST_TAKE;
        else                     state_next = gnpm_pkg::ST_EMIT;
      gnpm_pkg::ST_EMIT:
        if (out_free) state_next = emit_final ? gnpm_pkg::ST_IDLE : gnpm_pkg::ST_TAKE;
      gnpm_pkg::ST_TAKE: state_next = gnpm_pkg::ST_SQRT;
      gnpm_pkg::ST_SQRT: if (sctl.done) state_next = gnpm_pkg::ST_SCAN;
      default: state_next = gnpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gnpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      have_pend <= 1'b0;
      found     <= 1'b0;
      tag_v     <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      tag_v <= state == gnpm_pkg::ST_SCAN;
      ta    <= a_cnt;
      tb    <= b_cnt;
      if (better) begin
        found   <= 1'b1;
        best_sq <= pm_q[gnpm_pkg::SQ_W-1:0];
        best_a  <= ta;
        best_b  <= tb;
      end
      // EMIT reloads the output register itself
      if (m_tvalid && m_tready && state != gnpm_pkg::ST_EMIT) m_tvalid <= 1'b0;

      case (state)
        gnpm_pkg::ST_IDLE: begin
          k         <= '0;
          a_cnt     <= '0;
          b_cnt     <= '0;
          have_pend <= 1'b0;
          found     <= 1'b0;
        end
        gnpm_pkg::ST_CUT: begin
          k        <= k + 3'd1;
          row_used <= '0;
          col_used <= '0;
          if (k == 3'd2) cut_sq <= sq;
        end
        gnpm_pkg::ST_PRD: k <= '0;
        gnpm_pkg::ST_AXIS: begin
          k <= k + 3'd1;
          if (k == 3'd2) begin
            acc <= sq;
            rej <= big;
          end else if (k > 3'd2) begin
            acc <= acc + sq;
            rej <= rej | big;
          end
        end
        gnpm_pkg::ST_PWR: begin
          if (b_end) begin
            b_cnt <= '0;
            a_cnt <= a_end ? '0 : a_cnt + AW'(1);
          end else begin
            b_cnt <= b_cnt + BW'(1);
          end
        end
        gnpm_pkg::ST_SCAN: begin
          if (b_end) begin
            b_cnt <= '0;
            a_cnt <= a_end ? '0 : a_cnt + AW'(1);
          end else begin
            b_cnt <= b_cnt + BW'(1);
          end
        end
        gnpm_pkg::ST_DECIDE: emit_final <= !found;
        gnpm_pkg::ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= have_pend;
            m_tlast  <= emit_final;
            m_tdata  <= have_pend ?
                        {4'b0, pend_d, gnpm_pkg::IDX_W'(pend_b), gnpm_pkg::IDX_W'(pend_a)} :
                        '0;
          end
        end
        gnpm_pkg::ST_TAKE: begin
          row_used[best_a] <= 1'b1;
          col_used[best_b] <= 1'b1;
        end
        gnpm_pkg::ST_SQRT: begin
          if (sctl.done) begin
            pend_a    <= best_a;
            pend_b    <= best_b;
            pend_d    <= root[gnpm_pkg::DIST_W-1:0];
            have_pend <= 1'b1;
            found     <= 1'b0;
            a_cnt     <= '0;
            b_cnt     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/gnpm_checker.sv
`include "greedy_nearest_pair_matcher_core_macros.svh"

module gnpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  `GNPM_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")
  `GNPM_ASSERT(a_empty_last, clk, rst, m_tvalid && !m_tuser |-> m_tlast, "empty result not marked last")
  `GNPM_ASSERT(a_empty_zero, clk, rst, m_tvalid && !m_tuser |-> m_tdata[35:0] == 36'd0, "empty result carries data")
  `GNPM_ASSERT(a_dist_nz, clk, rst, m_tvalid && m_tuser |-> m_tdata[35:12] != 24'd0, "matched pair with zero distance")
  `GNPM_ASSERT_NR(a_rst_idle, clk, rst |=> !m_tvalid, "result valid right after reset")

endmodule

bind greedy_nearest_pair_matcher_core gnpm_checker u_gnpm_checker (.*);

>>> sim/testbench.sv
module testbench;

  // One expected result word of a match run.
  typedef struct packed {
    bit        valid;
    bit [5:0]  a_idx;
    bit [5:0]  b_idx;
    bit [23:0] pdist;
    bit        last;
  } pair_word_t;

  // Tracks particle positions and registers, and works out the greedy
  // pairing of each run word.
  class pair_scoreboard;
    longint     pa[3][64];
    longint     pb[3][64];
    longint     box_len[3];
    int         n_a, n_b;
    longint     cut;
    pair_word_t expected_pairs[$];
    int         mismatches;

    function new();
      n_a = 64;
      n_b = 64;
      cut = 32768;
      foreach (box_len[k]) box_len[k] = 655360;
      mismatches = 0;
    endfunction

    function void write_reg(logic [gnpm_pkg::CFG_IDX_W-1:0] idx,
                            logic [gnpm_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        gnpm_pkg::REG_COUNT_A: n_a = int'(d[6:0]);
        gnpm_pkg::REG_COUNT_B: n_b = int'(d[6:0]);
        gnpm_pkg::REG_CUTOFF:  cut = longint'(d);
        gnpm_pkg::REG_BOX_X:   box_len[0] = longint'(d);
        gnpm_pkg::REG_BOX_Y:   box_len[1] = longint'(d);
        gnpm_pkg::REG_BOX_Z:   box_len[2] = longint'(d);
        default: ;
      endcase
    endfunction

    // Minimum image, folded at most once; exactly half a box stays put.
    function longint wrap(longint d, longint len);
      if (2 * d > len) return d - len;
      if (2 * d < -len) return d + len;
      return d;
    endfunction

    function longint floor_root(longint v);
      longint r, t;
      r = 0;
      for (int bitpos = 25; bitpos >= 0; bitpos--) begin
        t = r | (64'sd1 <<< bitpos);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void note_word(logic [1:0] act, logic [5:0] idx,
                            logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z);
      longint     sq[64][64];
      bit         keep[64][64];
      int         na, nb, ba, bb, found;
      longint     cut_sq, d, s;
      bit         fits;
      pair_word_t w;
      if (act == gnpm_pkg::ACT_LOAD_A) begin
        pa[0][idx] = longint'(x); pa[1][idx] = longint'(y); pa[2][idx] = longint'(z);
        return;
      end
      if (act == gnpm_pkg::ACT_LOAD_B) begin
        pb[0][idx] = longint'(x); pb[1][idx] = longint'(y); pb[2][idx] = longint'(z);
        return;
      end
      if (act != gnpm_pkg::ACT_RUN) return;
      na = (n_a > 64) ? 64 : n_a;
      nb = (n_b > 64) ? 64 : n_b;
      cut_sq = cut * cut;
      for (int i = 0; i < na; i++)
        for (int j = 0; j < nb; j++) begin
          s = 0;
          fits = 1;
          for (int k = 0; k < 3; k++) begin
            d = wrap(pa[k][i] - pb[k][j], box_len[k]);
            if (d < 0) d = -d;
            if (d > 64'sd16777216) fits = 0;
            s += d * d;
          end
          sq[i][j] = s;
          keep[i][j] = fits && s >= 4295 && s <= cut_sq;
        end
      found = 0;
      forever begin
        ba = -1;
        for (int i = 0; i < na; i++)
          for (int j = 0; j < nb; j++)
            if (keep[i][j] && (ba < 0 || sq[i][j] < sq[ba][bb])) begin
              ba = i;
              bb = j;
            end
        if (ba < 0) break;
        w.valid = 1;
        w.a_idx = 6'(ba);
        w.b_idx = 6'(bb);
        w.pdist = 24'(floor_root(sq[ba][bb]));
        w.last  = 0;
        expected_pairs.insert(expected_pairs.size(), w);
        found++;
        for (int j = 0; j < nb; j++) keep[ba][j] = 0;
        for (int i = 0; i < na; i++) keep[i][bb] = 0;
      end
      if (found == 0) begin
        w = '{0, 0, 0, 0, 1};
        expected_pairs.insert(expected_pairs.size(), w);
      end else
        expected_pairs[$].last = 1;
    endfunction

    function void check_word(pair_word_t got);
      pair_word_t exp_w;
      if (expected_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: valid=%0d a=%0d b=%0d dist=%0d last=%0d",
                   got.valid, got.a_idx, got.b_idx, got.pdist, got.last);
        return;
      end
      exp_w = expected_pairs.pop_front();
      if (got != exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: exp valid=%0d a=%0d b=%0d dist=%0d last=%0d,",
                    " got valid=%0d a=%0d b=%0d dist=%0d last=%0d"},
                   exp_w.valid, exp_w.a_idx, exp_w.b_idx, exp_w.pdist, exp_w.last,
                   got.valid, got.a_idx, got.b_idx, got.pdist, got.last);
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [gnpm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gnpm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pair_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  greedy_nearest_pair_matcher_core DUT (.*);

  always #10 clk = ~clk;

  // Receiver: the stall pattern switches at random between always ready, coin-flip ready and mostly stalled.
  int rx_phase = 0;
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 150 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    pair_word_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.valid = m_tuser;
      got.a_idx = m_tdata[5:0];
      got.b_idx = m_tdata[11:6];
      got.pdist = m_tdata[35:12];
      got.last  = m_tlast;
      sb.check_word(got);
    end
  end

  // Watchdog on words moving on any channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] act, logic [5:0] idx,
                           logic [23:0] x, logic [23:0] y, logic [23:0] z);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, z, y, x, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_word(act, idx, x, y, z);
  endtask

  // Sender pause: wait for every pending result, then let the block settle.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_pairs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [gnpm_pkg::CFG_IDX_W-1:0] idx,
                           logic [gnpm_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(int na, int nb, int c, int bx, int by, int bz);
    write_cfg(gnpm_pkg::REG_COUNT_A, 24'(na));
    write_cfg(gnpm_pkg::REG_COUNT_B, 24'(nb));
    write_cfg(gnpm_pkg::REG_CUTOFF, 24'(c));
    write_cfg(gnpm_pkg::REG_BOX_X, 24'(bx));
    write_cfg(gnpm_pkg::REG_BOX_Y, 24'(by));
    write_cfg(gnpm_pkg::REG_BOX_Z, 24'(bz));
  endtask

  // Coordinate near a center, within about +-1 nm, or fully random.
  function automatic logic [23:0] coord(int center, bit wild);
    if (wild) return 24'($urandom);
    return 24'(center + $urandom_range(0, 131071) - 65536);
  endfunction

  initial begin
    int na, nb, ctr;
    bit wild;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every position gets written once so no run reads an unloaded slot.
    for (int i = 0; i < 64; i++) begin
      send_word(gnpm_pkg::ACT_LOAD_A, 6'(i), coord(0, 0), coord(0, 0), coord(0, 0));
      send_word(gnpm_pkg::ACT_LOAD_B, 6'(i), coord(0, 0), coord(0, 0), coord(0, 0));
    end
    // Full-size run on reset registers.
    send_word(gnpm_pkg::ACT_RUN, 0, 0, 0, 0);
    drain();

    // Half box: dx of 1000 in a box of 2000 is not folded.
    set_all(2, 2, 24'hFFFFFF, 2000, 24'hFFFFFF, 1);
    send_word(gnpm_pkg::ACT_LOAD_A, 0, 1000, 0, 0);
    send_word(gnpm_pkg::ACT_LOAD_B, 0, 0, 0, 0);
    send_word(gnpm_pkg::ACT_LOAD_A, 1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_word(gnpm_pkg::ACT_LOAD_B, 1, 24'h800000, 24'h800000, 24'h800000);
    send_word(gnpm_pkg::ACT_RUN, 0, 0, 0, 0);
    send_word(2'd3, 6'h3F, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    drain();

    // Ties in row-major order, and the 1e-3 nm floor on both sides.
    set_all(2, 4, 200000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_word(gnpm_pkg::ACT_LOAD_A, 0, 0, 0, 0);
    send_word(gnpm_pkg::ACT_LOAD_A, 1, 500000, 0, 0);
    send_word(gnpm_pkg::ACT_LOAD_B, 0, 100000, 0, 0);
    send_word(gnpm_pkg::ACT_LOAD_B, 1, 24'(-100000), 0, 0);
    send_word(gnpm_pkg::ACT_LOAD_B, 2, 500065, 0, 0);
    send_word(gnpm_pkg::ACT_LOAD_B, 3, 500065, 9, 0);
    send_word(gnpm_pkg::ACT_RUN, 0, 0, 0, 0);
    drain();

    // Zero cutoff, zero counts and oversized counts.
    set_all(3, 3, 0, 1, 1, 1);
    send_word(gnpm_pkg::ACT_RUN, 0, 0, 0, 0);
    drain();
    set_all(0, 127, 24'hFFFFFF, 655360, 655360, 655360);
    send_word(gnpm_pkg::ACT_RUN, 0, 0, 0, 0);
    drain();
    set_all(127, 1, 24'hFFFFFF, 655360, 655360, 655360);
    send_word(gnpm_pkg::ACT_RUN, 0, 0, 0, 0);
    drain();

    // Random phases: registers, a frame of loads, a run; some noise words.
    for (int ph = 0; ph < 8; ph++) begin
      na = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      wild = ($urandom_range(0, 5) == 0);
      ctr = $urandom_range(0, 2097152) - 1048576;
      case ($urandom_range(0, 3))
        0: set_all(na, nb, $urandom_range(30000, 200000), 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        1: set_all(na, nb, $urandom_range(30000, 200000), $urandom_range(65536, 200000),
                   $urandom_range(65536, 200000), $urandom_range(65536, 200000));
        2: set_all(na, nb, $urandom, $urandom_range(1, 24'hFFFFFF),
                   $urandom_range(1, 24'hFFFFFF), $urandom_range(1, 24'hFFFFFF));
        default: set_all(na, nb, $urandom_range(60000, 120000), 655360, 655360, 655360);
      endcase
      for (int i = 0; i < 16; i++) begin
        if (i < na) send_word(gnpm_pkg::ACT_LOAD_A, 6'(i), coord(ctr, wild),
                              coord(ctr, wild), coord(ctr, wild));
        if (i < nb) send_word(gnpm_pkg::ACT_LOAD_B, 6'(i), coord(ctr, wild),
                              coord(ctr, wild), coord(ctr, wild));
        if ($urandom_range(0, 15) == 0)
          send_word($urandom_range(0, 1) ? 2'd3 : gnpm_pkg::ACT_LOAD_B, 6'($urandom),
                    24'($urandom), 24'($urandom), 24'($urandom));
      end
      send_word(gnpm_pkg::ACT_RUN, 6'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom));
      if ($urandom_range(0, 1)) send_word(gnpm_pkg::ACT_RUN, 0, 0, 0, 0);
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_pairs.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> greedy_nearest_pair_matcher_core.f
+incdir+rtl/core
rtl/core/gnpm_pkg.sv
rtl/core/gnpm_sq_unit.sv
rtl/core/gnpm_isqrt.sv
rtl/core/greedy_nearest_pair_matcher_core.sv
rtl/core/gnpm_checker.sv
sim/testbench.sv
